[hw/rtl/bbpg_pkg.sv]
// shared types and codes of the buzzer beep pattern generator
package bbpg_pkg;

  // command codes carried on the input tuser
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;

  // pattern codes
  localparam logic [2:0] PAT_BEEPS  = 3'd0;
  localparam logic [2:0] PAT_HUMAN  = 3'd1;
  localparam logic [2:0] PAT_SINGLE = 3'd2;
  localparam logic [2:0] PAT_INF    = 3'd3;
  localparam logic [2:0] PAT_FAST   = 3'd4;

  // field widths and bus widths
  localparam int MODE_W     = 2;
  localparam int PATTERN_W  = 3;
  localparam int COUNT_W    = 8;
  localparam int DUR_IN_W   = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 8;

  // one input transaction
  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [PATTERN_W-1:0] pattern;
    logic [COUNT_W-1:0]   count;
    logic [DUR_IN_W-1:0]  tone_len;
  } bbpg_item_t;

  // one result transaction
  typedef struct packed {
    logic error;
    logic busy_res;
    logic buzzer;
  } bbpg_res_t;

endpackage

[hw/rtl/buzzer_beep_pattern_generator.sv]
// top level of the buzzer beep pattern generator: stream ports and pipeline registers
//
// Input channel in_*: in_tuser carries the command (tick of 1 ms, start, stop),
// in_tdata the start arguments (pattern, beep count, single beep length in ms).
// Every input transaction, whatever its command, yields exactly one result
// transaction on out_*, carrying the buzzer level, the busy flag and the
// zero-length error flag as they stand after that transaction.
// A transaction passes from the input register through the state update into
// the result register, which presents its result; a stalled receiver can hold
// it in the input register until the result register frees.
// Throughput: one transaction per cycle while results are taken; the state update
// is a short step of small counters between the input and the result register.
// A stalled receiver holds the result register; the input register still
// accepts one further transaction, after which in_tready falls until the
// result is taken.
// Reset (rst_n low, synchronous) empties both registers and leaves the
// generator idle and silent with no pattern running.
module buzzer_beep_pattern_generator
  import bbpg_pkg::*;
#(
  parameter int DURATION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // pattern[2:0], count[10:3], tone_len[26:11]
  input  logic [MODE_W-1:0]     in_tuser,   // mode[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // buzzer[0], busy_res[1], error[2]
);

  bbpg_item_t item_r;
  logic       item_vld_r;
  bbpg_res_t  res_c;
  bbpg_res_t  res_r;
  logic       out_vld_r;
  logic       adv;

  // the result register frees when empty or taken
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = !item_vld_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.mode     <= in_tuser;
      item_r.pattern  <= in_tdata[PATTERN_W-1:0];
      item_r.count    <= in_tdata[PATTERN_W+COUNT_W-1:PATTERN_W];
      item_r.tone_len <= in_tdata[PATTERN_W+COUNT_W+DUR_IN_W-1:PATTERN_W+COUNT_W];
    end
  end

  bbpg_core #(
    .DURATION_BITS(DURATION_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(item_vld_r && adv),
    .item   (item_r),
    .res    (res_c)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= item_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && item_vld_r) begin
      res_r <= res_c;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_DATA_W-3){1'b0}}, res_r};

  // a sounding buzzer always belongs to a running pattern
  a_buzz_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[1])
    else $error("buzzer on while not busy");

  // a rejected start leaves the block idle
  a_err_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> !out_tdata[1])
    else $error("error flagged while busy");

  // an empty result register never holds off the input
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // the pipeline never drops a transaction while the receiver stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && item_vld_r |=> out_tvalid && item_vld_r)
    else $error("transaction lost under stall");

endmodule

[hw/rtl/bbpg_core.sv]
// pattern state machine: phase, counters and per-transaction result
module bbpg_core
  import bbpg_pkg::*;
#(
  parameter int DURATION_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  bbpg_item_t item,
  output bbpg_res_t  res
);

  // the counter must also hold the 700 ms long gap
  localparam int MS_W = (DURATION_BITS > 10) ? DURATION_BITS : 10;
  localparam logic [32:0] DUR_MAX = (33'd1 << DURATION_BITS) - 33'd1;

  localparam logic [MS_W-1:0] MS_BEEP      = MS_W'(100);
  localparam logic [MS_W-1:0] MS_GROUP_GAP = MS_W'(700);
  localparam logic [MS_W-1:0] MS_SHORT_ON  = MS_W'(50);
  localparam logic [MS_W-1:0] MS_INF_GAP   = MS_W'(500);
  localparam logic [MS_W-1:0] MS_FAST_GAP  = MS_W'(200);
  localparam logic [1:0]      GROUP_LEN    = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ON   = 2'd1,
    PH_OFF  = 2'd2
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [2:0]        pat_r, pat_nxt;
  logic [MS_W-1:0]   ms_r, ms_nxt;
  logic [COUNT_W-1:0] beeps_r, beeps_nxt;
  logic [1:0]        grp_r, grp_nxt;
  logic              err;
  logic [MS_W-1:0]   ms_dec;
  logic [1:0]        grp_inc;
  logic [32:0]       dur_ext;
  logic [MS_W-1:0]   dur_sat;

  // saturate the single beep length to the counter range
  assign dur_ext = {{(33-DUR_IN_W){1'b0}}, item.tone_len};
  assign dur_sat = (dur_ext > DUR_MAX) ? DUR_MAX[MS_W-1:0] : dur_ext[MS_W-1:0];
  assign ms_dec  = (ms_r == '0) ? '0 : ms_r - MS_W'(1);
  assign grp_inc = grp_r + 2'd1;

  // next state for the transaction in hand
  always_comb begin
    phase_nxt = phase_r;
    pat_nxt   = pat_r;
    ms_nxt    = ms_r;
    beeps_nxt = beeps_r;
    grp_nxt   = grp_r;
    err       = 1'b0;
    unique case (item.mode)
      MODE_TICK: begin
        unique case (phase_r)
          PH_IDLE: ;
          PH_ON: begin
            ms_nxt = ms_dec;
            if (ms_dec == '0) begin
              // end of a sounding phase
              case (pat_r)
                PAT_BEEPS: begin
                  if (beeps_r != '0) beeps_nxt = beeps_r - COUNT_W'(1);
                  phase_nxt = PH_OFF;
                  ms_nxt    = MS_BEEP;
                end
                PAT_HUMAN: begin
                  if (beeps_r != '0) beeps_nxt = beeps_r - COUNT_W'(1);
                  phase_nxt = PH_OFF;
                  if (grp_inc >= GROUP_LEN) begin
                    grp_nxt = '0;
                    ms_nxt  = MS_GROUP_GAP;
                  end else begin
                    grp_nxt = grp_inc;
                    ms_nxt  = MS_BEEP;
                  end
                end
                PAT_INF: begin
                  phase_nxt = PH_OFF;
                  ms_nxt    = MS_INF_GAP;
                end
                PAT_FAST: begin
                  phase_nxt = PH_OFF;
                  ms_nxt    = MS_FAST_GAP;
                end
                default: begin
                  phase_nxt = PH_IDLE;
                  ms_nxt    = '0;
                  beeps_nxt = '0;
                  grp_nxt   = '0;
                end
              endcase
            end
          end
          PH_OFF: begin
            ms_nxt = ms_dec;
            if (ms_dec == '0) begin
              // end of a gap
              if (pat_r == PAT_INF || pat_r == PAT_FAST) begin
                phase_nxt = PH_ON;
                ms_nxt    = MS_SHORT_ON;
              end else if ((pat_r == PAT_BEEPS || pat_r == PAT_HUMAN) && beeps_r != '0) begin
                phase_nxt = PH_ON;
                ms_nxt    = MS_BEEP;
              end else begin
                phase_nxt = PH_IDLE;
                ms_nxt    = '0;
                beeps_nxt = '0;
                grp_nxt   = '0;
              end
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
            ms_nxt    = '0;
            beeps_nxt = '0;
            grp_nxt   = '0;
          end
        endcase
      end
      MODE_START: begin
        // abort whatever runs, then launch the new pattern unless it is unknown or empty
        phase_nxt = PH_IDLE;
        ms_nxt    = '0;
        beeps_nxt = '0;
        grp_nxt   = '0;
        pat_nxt   = item.pattern;
        case (item.pattern) inside
          PAT_BEEPS, PAT_HUMAN: begin
            if (item.count != '0) begin
              beeps_nxt = item.count;
              phase_nxt = PH_ON;
              ms_nxt    = MS_BEEP;
            end
          end
          PAT_SINGLE: begin
            if (item.tone_len == '0) begin
              err = 1'b1;
            end else begin
              phase_nxt = PH_ON;
              ms_nxt    = dur_sat;
            end
          end
          PAT_INF, PAT_FAST: begin
            phase_nxt = PH_ON;
            ms_nxt    = MS_SHORT_ON;
          end
          default: ;
        endcase
      end
      MODE_STOP: begin
        phase_nxt = PH_IDLE;
        ms_nxt    = '0;
        beeps_nxt = '0;
        grp_nxt   = '0;
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pat_r   <= '0;
      ms_r    <= '0;
      beeps_r <= '0;
      grp_r   <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      pat_r   <= pat_nxt;
      ms_r    <= ms_nxt;
      beeps_r <= beeps_nxt;
      grp_r   <= grp_nxt;
    end
  end

  // result seen after this transaction
  assign res.buzzer   = (phase_nxt == PH_ON);
  assign res.busy_res = (phase_nxt != PH_IDLE);
  assign res.error    = err;

endmodule

[tb/buzzer_beep_pattern_generator_test.sv]
// self-checking testbench of the buzzer beep pattern generator
`timescale 1ns / 100ps

module buzzer_beep_pattern_generator_test;
  import bbpg_pkg::*;

  // command and pattern codes the package leaves unnamed
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [2:0] PAT_TOP     = 3'd7;

  // pattern timing in ms, and the group size
  localparam int BEEP_MS       = 100;
  localparam int GROUP_GAP_MS  = 700;
  localparam int GROUP_SIZE    = 3;
  localparam int SHORT_BEEP_MS = 50;
  localparam int SLOW_GAP_MS   = 500;
  localparam int FAST_GAP_MS   = 200;

  localparam int RANDOM_ITEMS  = 1200;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RX_HOLD_LONG  = 80;

  typedef enum logic [1:0] {TONE_IDLE, TONE_ON, TONE_OFF} tone_phase_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // pattern[2:0], count[10:3], tone_len[26:11]
  logic [MODE_W-1:0]     in_tuser = '0;   // mode[1:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // buzzer[0], busy_res[1], error[2]

  // predicted generator state
  tone_phase_t  tone_phase = TONE_IDLE;
  logic [2:0]   cur_pattern = PAT_BEEPS;
  logic [31:0]  ms_remaining = '0;
  logic [7:0]   beeps_remaining = '0;
  logic [1:0]   group_count = '0;

  bbpg_res_t    expected_levels[$];

  int  mismatch_count = 0;
  int  items_sent = 0;
  int  results_checked = 0;
  int  buzz_on_seen = 0;
  int  error_seen = 0;
  int  longest_hold = 0;
  int  rx_hold_len = 0;
  int  cycle_count = 0;
  bit  tx_gaps_on = 1'b1;
  bit  rx_gaps_on = 1'b1;

  buzzer_beep_pattern_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run stopped at cycle limit with %0d results outstanding",
               expected_levels.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // abort whatever runs and fall silent
  function automatic void silence_tone();
    tone_phase      = TONE_IDLE;
    ms_remaining    = '0;
    beeps_remaining = '0;
    group_count     = '0;
  endfunction

  // advance the predicted state by one transaction and give its result
  function automatic bbpg_res_t step_tone_state(input logic [1:0] mode,
                                                input logic [2:0] pat,
                                                input logic [7:0] cnt,
                                                input logic [15:0] dur);
    bbpg_res_t res;
    logic      err;
    err = 1'b0;
    case (mode)
      MODE_TICK: begin
        if (tone_phase != TONE_IDLE) begin
          if (ms_remaining != 0) ms_remaining = ms_remaining - 32'd1;
          if (ms_remaining == 0) begin
            if (tone_phase == TONE_ON) begin
              // end of a sounding stretch
              case (cur_pattern)
                PAT_BEEPS: begin
                  if (beeps_remaining != 0) beeps_remaining = beeps_remaining - 8'd1;
                  tone_phase   = TONE_OFF;
                  ms_remaining = BEEP_MS;
                end
                PAT_HUMAN: begin
                  if (beeps_remaining != 0) beeps_remaining = beeps_remaining - 8'd1;
                  group_count = group_count + 2'd1;
                  tone_phase  = TONE_OFF;
                  if (group_count >= GROUP_SIZE) begin
                    group_count  = '0;
                    ms_remaining = GROUP_GAP_MS;
                  end else begin
                    ms_remaining = BEEP_MS;
                  end
                end
                PAT_INF: begin
                  tone_phase   = TONE_OFF;
                  ms_remaining = SLOW_GAP_MS;
                end
                PAT_FAST: begin
                  tone_phase   = TONE_OFF;
                  ms_remaining = FAST_GAP_MS;
                end
                default: silence_tone();
              endcase
            end else if (cur_pattern == PAT_INF || cur_pattern == PAT_FAST) begin
              // end of a gap
              tone_phase   = TONE_ON;
              ms_remaining = SHORT_BEEP_MS;
            end else if ((cur_pattern == PAT_BEEPS || cur_pattern == PAT_HUMAN) &&
                         beeps_remaining != 0) begin
              tone_phase   = TONE_ON;
              ms_remaining = BEEP_MS;
            end else begin
              silence_tone();
            end
          end
        end
      end
      MODE_START: begin
        silence_tone();
        cur_pattern = pat;
        case (pat) inside
          PAT_BEEPS, PAT_HUMAN: begin
            if (cnt != 0) begin
              beeps_remaining = cnt;
              tone_phase      = TONE_ON;
              ms_remaining    = BEEP_MS;
            end
          end
          PAT_SINGLE: begin
            // a 16 bit length never exceeds the saturation point at this width
            if (dur == 0) begin
              err = 1'b1;
            end else begin
              tone_phase   = TONE_ON;
              ms_remaining = 32'(dur);
            end
          end
          PAT_INF, PAT_FAST: begin
            tone_phase   = TONE_ON;
            ms_remaining = SHORT_BEEP_MS;
          end
          default: ;
        endcase
      end
      MODE_STOP: silence_tone();
      default: ;
    endcase
    res.buzzer   = (tone_phase == TONE_ON);
    res.busy_res = (tone_phase != TONE_IDLE);
    res.error    = err;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic want, input logic got);
    $display("mismatch in result %0d: %s expected %0b got %0b",
             results_checked, what, want, got);
    mismatch_count++;
  endtask

  // offer one transaction and record its predicted result once taken
  task automatic send_item(input logic [1:0] mode, input logic [2:0] pat,
                           input logic [7:0] cnt, input logic [15:0] dur);
    int   gap;
    logic taken;
    gap = tx_gaps_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {{(IN_DATA_W - 27){1'b0}}, dur, cnt, pat};
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    expected_levels.push_back(step_tone_state(mode, pat, cnt, dur));
    items_sent++;
  endtask

  // millisecond ticks with junk in the unused data fields
  task automatic run_ticks(input int n);
    repeat (n) send_item(MODE_TICK, 3'($urandom), 8'($urandom), 16'($urandom));
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, plus a long hold when a test asks for one
  always begin
    int   stall;
    int   held;
    logic got_one;
    if (rx_hold_len > 0) begin
      stall       = rx_hold_len;
      rx_hold_len = 0;
    end else begin
      stall = rx_gaps_on ? $urandom_range(0, 9) : 0;
    end
    if (stall > 0) begin
      out_tready <= 1'b0;
      held = 0;
      while (held < stall) begin
        @(posedge clk);
        held++;
      end
      if (held > longest_hold) longest_hold = held;
    end
    out_tready <= 1'b1;
    do begin
      @(negedge clk);
      got_one = out_tvalid;
      @(posedge clk);
    end while (!got_one);
  end

  // compare each result transaction with the oldest prediction
  always begin
    bbpg_res_t got;
    bbpg_res_t want;
    @(negedge clk);
    if (rst_n && out_tvalid && out_tready) begin
      got = bbpg_res_t'(out_tdata[2:0]);
      if (expected_levels.size() == 0) begin
        $display("result %0d arrived with nothing outstanding", results_checked);
        mismatch_count++;
      end else begin
        want = expected_levels.pop_front();
        if (got.buzzer !== want.buzzer) report_mismatch("buzzer", want.buzzer, got.buzzer);
        if (got.busy_res !== want.busy_res)
          report_mismatch("busy_res", want.busy_res, got.busy_res);
        if (got.error !== want.error) report_mismatch("error", want.error, got.error);
      end
      if (got.buzzer === 1'b1) buzz_on_seen++;
      if (got.error === 1'b1) error_seen++;
      results_checked++;
    end
  end

  // commands while idle, rejected starts, field extremes and short runs
  task automatic test_commands_at_rest();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    send_item(MODE_TICK, PAT_BEEPS, 8'h00, 16'h0000);
    send_item(MODE_STOP, PAT_TOP, 8'hFF, 16'hFFFF);
    send_item(MODE_UNUSED, PAT_TOP, 8'hFF, 16'hFFFF);
    send_item(MODE_START, PAT_BEEPS, 8'h00, 16'hFFFF);
    send_item(MODE_START, PAT_HUMAN, 8'h00, 16'h0000);
    send_item(MODE_START, PAT_SINGLE, 8'hFF, 16'h0000);
    send_item(MODE_TICK, PAT_SINGLE, 8'h00, 16'h0000);
    send_item(MODE_START, PAT_FAST + 3'd1, 8'h01, 16'h0001);
    send_item(MODE_START, PAT_TOP, 8'hFF, 16'hFFFF);
    send_item(MODE_START, PAT_SINGLE, 8'h00, 16'hFFFF);
    send_item(MODE_TICK, PAT_TOP, 8'hFF, 16'hFFFF);
    send_item(MODE_STOP, PAT_BEEPS, 8'h00, 16'h0000);
    send_item(MODE_START, PAT_BEEPS, 8'hFF, 16'h0000);
    send_item(MODE_TICK, PAT_BEEPS, 8'h00, 16'h0000);
    send_item(MODE_STOP, PAT_BEEPS, 8'h00, 16'h0000);
    send_item(MODE_START, PAT_HUMAN, 8'hFF, 16'hFFFF);
    send_item(MODE_STOP, PAT_HUMAN, 8'hFF, 16'hFFFF);
    send_item(MODE_START, PAT_INF, 8'h00, 16'h0000);
    send_item(MODE_UNUSED, PAT_BEEPS, 8'h00, 16'h0000);
    send_item(MODE_STOP, PAT_INF, 8'h00, 16'h0000);
    send_item(MODE_START, PAT_FAST, 8'h00, 16'h0000);
    send_item(MODE_STOP, PAT_FAST, 8'h00, 16'h0000);
    // shortest single beep ends on the first tick
    send_item(MODE_START, PAT_SINGLE, 8'h00, 16'h0001);
    run_ticks(2);
    drain_results();
  endtask

  // each pattern played through to its end or for several periods
  task automatic test_pattern_walk();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    send_item(MODE_START, PAT_BEEPS, 8'd2, 16'h0000);
    run_ticks(4 * BEEP_MS + 3);
    // four beeps cross one long group gap
    send_item(MODE_START, PAT_HUMAN, 8'd4, 16'h0000);
    run_ticks(7 * BEEP_MS + GROUP_GAP_MS + 3);
    send_item(MODE_START, PAT_SINGLE, 8'h00, 16'd37);
    run_ticks(40);
    send_item(MODE_START, PAT_INF, 8'h00, 16'h0000);
    run_ticks(2 * (SHORT_BEEP_MS + SLOW_GAP_MS) + 60);
    send_item(MODE_STOP, PAT_INF, 8'h00, 16'h0000);
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    send_item(MODE_START, PAT_FAST, 8'h00, 16'h0000);
    run_ticks(2 * (SHORT_BEEP_MS + FAST_GAP_MS) + 20);
    send_item(MODE_STOP, PAT_FAST, 8'h00, 16'h0000);
    drain_results();
  endtask

  // a running pattern cut short by other starts, noise and stop
  task automatic test_abort_midway();
    send_item(MODE_START, PAT_INF, 8'h00, 16'h0000);
    run_ticks(30);
    send_item(MODE_START, PAT_BEEPS, 8'd3, 16'h0000);
    run_ticks(150);
    send_item(MODE_UNUSED, PAT_SINGLE, 8'h55, 16'hAAAA);
    send_item(MODE_START, PAT_HUMAN, 8'd5, 16'h0000);
    run_ticks(120);
    send_item(MODE_START, PAT_SINGLE, 8'h00, 16'h0000);
    send_item(MODE_START, PAT_SINGLE, 8'h00, 16'd500);
    run_ticks(20);
    send_item(MODE_START, PAT_FAST + 3'd2, 8'hAA, 16'h5555);
    run_ticks(5);
    send_item(MODE_START, PAT_FAST, 8'h00, 16'h0000);
    run_ticks(60);
    send_item(MODE_STOP, PAT_BEEPS, 8'h00, 16'h0000);
    run_ticks(3);
    drain_results();
  endtask

  // receiver holds off long while the sender keeps offering
  task automatic test_backpressure();
    tx_gaps_on  = 1'b0;
    rx_gaps_on  = 1'b1;
    rx_hold_len = RX_HOLD_LONG;
    send_item(MODE_START, PAT_FAST, 8'h00, 16'h0000);
    run_ticks(60);
    send_item(MODE_STOP, PAT_FAST, 8'h00, 16'h0000);
    drain_results();
  endtask

  // well-formed starts followed by tick runs, mixed with noise
  task automatic test_random_sequences();
    int first_item;
    int pick;
    int run_len;
    first_item = items_sent;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_item(MODE_START, 3'($urandom_range(PAT_BEEPS, PAT_FAST)),
                  ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(1, 4)),
                  ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 120)));
        run_len = $urandom_range(1, 250);
        repeat (run_len) begin
          if ($urandom_range(0, 49) == 0)
            send_item(MODE_UNUSED, 3'($urandom), 8'($urandom), 16'($urandom));
          else
            run_ticks(1);
        end
      end else if (pick < 85) begin
        send_item(MODE_START, 3'($urandom), 8'($urandom), 16'($urandom));
      end else if (pick < 93) begin
        send_item(MODE_STOP, 3'($urandom), 8'($urandom), 16'($urandom));
      end else begin
        send_item(MODE_UNUSED, 3'($urandom), 8'($urandom), 16'($urandom));
      end
    end
    drain_results();
  endtask

  // main sequence
  initial begin
    silence_tone();
    cur_pattern = PAT_BEEPS;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_commands_at_rest();
    test_pattern_walk();
    test_abort_midway();
    test_backpressure();
    test_random_sequences();
    repeat (4) @(posedge clk);
    $display("sent %0d transactions, checked %0d results (%0d sounding, %0d rejected starts)",
             items_sent, results_checked, buzz_on_seen, error_seen);
    $display("all five patterns, aborts and stops exercised; longest receiver hold %0d cycles",
             longest_hold);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

[files.f]
hw/rtl/bbpg_pkg.sv
hw/rtl/bbpg_core.sv
hw/rtl/buzzer_beep_pattern_generator.sv
tb/buzzer_beep_pattern_generator_test.sv
